>>> hw/rtl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants for the flight phase sequencer: phase codes,
// register indexes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

  // Field widths
  localparam int unsigned AccelW  = 16;
  localparam int unsigned AltW    = 24;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned MsW     = 16;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  // Flight phases, as reported on the result channel
  typedef enum logic [PhaseW-1:0] {
    PH_PRE         = 3'd0,
    PH_ASCENT      = 3'd1,
    PH_POST_APOGEE = 3'd2,
    PH_DESCENT     = 3'd3,
    PH_TOUCHDOWN   = 3'd4
  } fps_phase_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ACCEL_THRESHOLD     = 3'd0,
    REG_ACCEL_COUNT_LIMIT   = 3'd1,
    REG_DESCENT_COUNT_LIMIT = 3'd2,
    REG_DEPLOY_ALT          = 3'd3,
    REG_APOGEE_DWELL_MS     = 3'd4,
    REG_MAIN_HOLD_MS        = 3'd5
  } fps_reg_idx_t;

  // Reset values (threshold is 2 g in 1/256 m/s^2, target is 116.0 in 1/16)
  localparam logic [AccelW-1:0]        RstAccelThreshold   = 16'd5023;
  localparam logic [CountW-1:0]        RstAccelCountLimit  = 8'd10;
  localparam logic [CountW-1:0]        RstDescentCountLim  = 8'd5;
  localparam logic signed [AltW-1:0]   RstTargetAltitude   = 24'sd1856;
  localparam logic [MsW-1:0]           RstApogeeDwellMs    = 16'd200;
  localparam logic [MsW-1:0]           RstMainHoldMs       = 16'd5000;

  localparam logic [CountW-1:0]        CountMax            = 8'hFF;

  // Live configuration
  typedef struct packed {
    logic [AccelW-1:0]      accel_threshold;
    logic [CountW-1:0]      accel_count_limit;
    logic [CountW-1:0]      descent_count_limit;
    logic signed [AltW-1:0] deploy_alt;
    logic [MsW-1:0]         apogee_dwell_ms;
    logic [MsW-1:0]         main_hold_ms;
  } fps_cfg_t;

  // One sensor sample held in the input register
  typedef struct packed {
    logic [AccelW-1:0]      accel_mag;
    logic signed [AltW-1:0] sample_altitude;
    logic [TimeW-1:0]       now_ms;
  } fps_sample_t;

  // One result beat
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              ignition_pulse;
    logic              drogue_fire;
    logic              main_fire;
  } fps_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/fps_cfg_regs.sv
// ----------------------------------------------------------------------------
// fps_cfg_regs
// Configuration register file: six write-only registers, indexed writes,
// out-of-range indexes ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fps_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [fps_pkg::CfgDatW-1:0]   cfg_wdata,
  output fps_pkg::fps_cfg_t                  cfg_o
);
  import fps_pkg::*;

  fps_cfg_t cfg_r;
  fps_cfg_t cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_THRESHOLD:     cfg_nxt.accel_threshold     = cfg_wdata[AccelW-1:0];
        REG_ACCEL_COUNT_LIMIT:   cfg_nxt.accel_count_limit   = cfg_wdata[CountW-1:0];
        REG_DESCENT_COUNT_LIMIT: cfg_nxt.descent_count_limit = cfg_wdata[CountW-1:0];
        REG_DEPLOY_ALT:          cfg_nxt.deploy_alt          = cfg_wdata[AltW-1:0];
        REG_APOGEE_DWELL_MS:     cfg_nxt.apogee_dwell_ms     = cfg_wdata[MsW-1:0];
        REG_MAIN_HOLD_MS:        cfg_nxt.main_hold_ms        = cfg_wdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_threshold     <= RstAccelThreshold;
      cfg_r.accel_count_limit   <= RstAccelCountLimit;
      cfg_r.descent_count_limit <= RstDescentCountLim;
      cfg_r.deploy_alt          <= RstTargetAltitude;
      cfg_r.apogee_dwell_ms     <= RstApogeeDwellMs;
      cfg_r.main_hold_ms        <= RstMainHoldMs;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/fps_core.sv
// ----------------------------------------------------------------------------
// fps_core
// Phase state machine with its counters and stamps. Evaluates the sample in
// the input register and commits the new state when the beat moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  fps_pkg::fps_cfg_t  cfg_i,
  input  fps_pkg::fps_sample_t smp_i,
  input  wire logic          take_i,
  output fps_pkg::fps_result_t res_o
);
  import fps_pkg::*;

  fps_phase_t             phase_r, phase_nxt;
  logic [CountW-1:0]      accel_hits_r, accel_hits_nxt;
  logic [CountW-1:0]      falling_run_r, falling_run_nxt;
  logic signed [AltW-1:0] last_alt_r;
  logic [TimeW-1:0]       stamp_r, stamp_nxt;

  logic [CountW-1:0]      hits_inc;
  logic [CountW-1:0]      run_inc;
  logic [TimeW-1:0]       elapsed;
  logic                   ignite, apogee, dwell_done, below_target, hold_done;
  logic                   ign, drogue, mainf;

  // Condition datapath
  always_comb begin
    hits_inc = accel_hits_r;
    if (smp_i.accel_mag >= cfg_i.accel_threshold && accel_hits_r != CountMax) begin
      hits_inc = CountW'(accel_hits_r + 8'd1);
    end
    run_inc = '0;
    if (smp_i.sample_altitude <= last_alt_r) begin
      run_inc = (falling_run_r == CountMax) ? falling_run_r
                                            : CountW'(falling_run_r + 8'd1);
    end
  end

  assign elapsed      = smp_i.now_ms - stamp_r;
  assign ignite       = hits_inc > cfg_i.accel_count_limit;
  assign apogee       = run_inc >= cfg_i.descent_count_limit;
  assign dwell_done   = elapsed > {{(TimeW-MsW){1'b0}}, cfg_i.apogee_dwell_ms};
  assign below_target = smp_i.sample_altitude <= cfg_i.deploy_alt;
  assign hold_done    = elapsed >= {{(TimeW-MsW){1'b0}}, cfg_i.main_hold_ms};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_PRE:         if (ignite) phase_nxt = PH_ASCENT;
      PH_ASCENT:      if (apogee) phase_nxt = PH_POST_APOGEE;
      PH_POST_APOGEE: if (dwell_done && below_target) phase_nxt = PH_DESCENT;
      PH_DESCENT:     if (hold_done) phase_nxt = PH_TOUCHDOWN;
      default:        phase_nxt = phase_r;
    endcase
  end

  // Per-phase outputs: counters, stamp and fire pulses
  always_comb begin
    accel_hits_nxt  = accel_hits_r;
    falling_run_nxt = falling_run_r;
    stamp_nxt       = stamp_r;
    ign             = 1'b0;
    drogue          = 1'b0;
    mainf           = 1'b0;
    unique case (phase_r)
      PH_PRE: begin
        accel_hits_nxt = hits_inc;
        ign            = ignite;
      end
      PH_ASCENT: begin
        falling_run_nxt = run_inc;
        drogue          = apogee;
        if (apogee) stamp_nxt = smp_i.now_ms;
      end
      PH_POST_APOGEE: begin
        mainf = dwell_done && below_target;
        if (mainf) stamp_nxt = smp_i.now_ms;
      end
      default: ;
    endcase
  end

  // State registers, committed once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_PRE;
      accel_hits_r  <= '0;
      falling_run_r <= '0;
      last_alt_r    <= '0;
      stamp_r       <= '0;
    end else if (take_i) begin
      phase_r       <= phase_nxt;
      accel_hits_r  <= accel_hits_nxt;
      falling_run_r <= falling_run_nxt;
      last_alt_r    <= smp_i.sample_altitude;
      stamp_r       <= stamp_nxt;
    end
  end

  assign res_o.phase          = phase_nxt;
  assign res_o.ignition_pulse = ign;
  assign res_o.drogue_fire    = drogue;
  assign res_o.main_fire      = mainf;

endmodule

`default_nettype wire

>>> hw/rtl/fps_pipe.sv
// ----------------------------------------------------------------------------
// fps_pipe
// Two-register pipeline: input register for the sample, result register
// for the outgoing beat, with stall passed back through both.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fps_pkg::AccelW-1:0]    in_accel_mag,
  input  wire logic signed [fps_pkg::AltW-1:0] in_sample_altitude,
  input  wire logic [fps_pkg::TimeW-1:0]     in_now_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fps_pkg::PhaseW-1:0]         out_phase,
  output logic                               out_ignition_pulse,
  output logic                               out_drogue_fire,
  output logic                               out_main_fire,
  output fps_pkg::fps_sample_t               smp_o,
  output logic                               take_o,
  input  fps_pkg::fps_result_t               res_i
);
  import fps_pkg::*;

  logic        s_valid_r;
  fps_sample_t s_data_r;
  logic        o_valid_r;
  fps_result_t o_data_r;
  logic        o_free;
  logic        s_free;

  // Result register can load when empty or being drained
  assign o_free   = !o_valid_r || !out_stall;
  assign take_o   = s_valid_r && o_free;
  assign s_free   = !s_valid_r || o_free;
  assign in_stall = !s_free;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (s_free) s_valid_r <= in_valid;
      if (o_free) o_valid_r <= s_valid_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s_free && in_valid) begin
      s_data_r.accel_mag       <= in_accel_mag;
      s_data_r.sample_altitude <= in_sample_altitude;
      s_data_r.now_ms          <= in_now_ms;
    end
    if (take_o) o_data_r <= res_i;
  end

  assign smp_o              = s_data_r;
  assign out_valid          = o_valid_r;
  assign out_phase          = o_data_r.phase;
  assign out_ignition_pulse = o_data_r.ignition_pulse;
  assign out_drogue_fire    = o_data_r.drogue_fire;
  assign out_main_fire      = o_data_r.main_fire;

endmodule

`default_nettype wire

>>> hw/rtl/flight_phase_sequencer_top.sv
// Path: a sample goes into the input register; its result beat is shown once
// the result register takes it. Throughput: one sample per clock while not
// stalled; both registers then advance together, and the phase state is
// updated once per beat. Reset (rst_n low, synchronous): phase preignition,
// counters, last altitude and event stamp cleared, registers at their defaults.
// ----------------------------------------------------------------------------
// flight_phase_sequencer_top
// Sensor-driven flight phase sequencer: ignition, apogee, main deployment
// and touchdown detection, one result beat per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module flight_phase_sequencer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [fps_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [fps_pkg::CfgDatW-1:0]     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fps_pkg::AccelW-1:0]      in_accel_mag,
  input  wire logic signed [fps_pkg::AltW-1:0] in_sample_altitude,
  input  wire logic [fps_pkg::TimeW-1:0]       in_now_ms,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [fps_pkg::PhaseW-1:0]           out_phase,
  output logic                                 out_ignition_pulse,
  output logic                                 out_drogue_fire,
  output logic                                 out_main_fire
);
  import fps_pkg::*;

  fps_cfg_t    cfg;
  fps_sample_t smp;
  fps_result_t res;
  logic        take;

  fps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  fps_pipe u_pipe (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_accel_mag       (in_accel_mag),
    .in_sample_altitude (in_sample_altitude),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_phase          (out_phase),
    .out_ignition_pulse (out_ignition_pulse),
    .out_drogue_fire    (out_drogue_fire),
    .out_main_fire      (out_main_fire),
    .smp_o              (smp),
    .take_o             (take),
    .res_i              (res)
  );

  fps_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg),
    .smp_i  (smp),
    .take_i (take),
    .res_o  (res)
  );

endmodule

`default_nettype wire

>>> hw/rtl/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks on the sequencer's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [fps_pkg::PhaseW-1:0]  out_phase,
  input wire logic                        out_ignition_pulse,
  input wire logic                        out_drogue_fire,
  input wire logic                        out_main_fire
);
  import fps_pkg::*;

  // At most one firing event per beat
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_ignition_pulse, out_drogue_fire, out_main_fire}))
    else $error("more than one firing event in one beat");

  // Each pulse comes with the phase it leads into
  a_ign_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ignition_pulse) |-> (out_phase == PH_ASCENT))
    else $error("ignition pulse outside ascent");

  a_drogue_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drogue_fire) |-> (out_phase == PH_POST_APOGEE))
    else $error("drogue fired outside post apogee");

  a_main_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_main_fire) |-> (out_phase == PH_DESCENT))
    else $error("main fired outside descent");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_phase)))
    else $error("stalled result beat changed");

endmodule

bind flight_phase_sequencer_top fps_checker u_fps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_phase          (out_phase),
  .out_ignition_pulse (out_ignition_pulse),
  .out_drogue_fire    (out_drogue_fire),
  .out_main_fire      (out_main_fire)
);

`default_nettype wire
